### hw/rtl/circle_point_generator_unit_assert.svh
// Assertion macros shared by the circle point generator RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef CIRCLE_POINT_GENERATOR_UNIT_ASSERT_SVH
`define CIRCLE_POINT_GENERATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define CPG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CPG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CPG_ASSERT_SAME(lbl, ante, cons, msg)
`define CPG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/cpg_pkg.sv
// Package of the circle point generator: widths, codes and the step record type.
// No dependencies.
`timescale 1ns / 1ps
package cpg_pkg;
	localparam int COORD_BITS  = 12;
	localparam int SCREEN_BITS = COORD_BITS + 2;
	localparam int DEC_BITS    = COORD_BITS + 4;
	localparam int CENTER_BITS = 12;
	localparam int RADIUS_BITS = 11;
	localparam int CFG_IDX_BITS = 2;

	typedef logic signed [COORD_BITS-1:0]  coord_t;
	typedef logic        [COORD_BITS-1:0]  ucoord_t;
	typedef logic signed [SCREEN_BITS-1:0] scr_t;
	typedef logic signed [DEC_BITS-1:0]    dec_t;
	typedef logic signed [CENTER_BITS-1:0] center_t;
	typedef logic        [RADIUS_BITS-1:0] radius_t;
	typedef logic        [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_ADVANCE = 1'b1;
	localparam logic ALGO_BRES   = 1'b0;
	localparam logic ALGO_MID    = 1'b1;

	localparam cfg_idx_t CFG_ALGORITHM = 2'd0;
	localparam cfg_idx_t CFG_ORIGIN_X  = 2'd1;
	localparam cfg_idx_t CFG_ORIGIN_Y  = 2'd2;

	localparam ucoord_t ORIGIN_X_RST = ucoord_t'(319);
	localparam ucoord_t ORIGIN_Y_RST = ucoord_t'(239);

	// One decided step: screen centre, step values and the done flag.
	typedef struct packed {
		scr_t   cx;
		scr_t   cy;
		coord_t x;
		coord_t y;
		logic   done;
	} step_t;

	typedef struct packed {
		logic  push;
		step_t data;
	} push_t;

	typedef struct packed {
		logic  full;
		logic  head_valid;
		step_t head;
	} queue_stat_t;
endpackage

### hw/rtl/cpg_in_if.sv
// Request channel of the circle point generator.
// Depends on cpg_pkg.
`timescale 1ns / 1ps
interface cpg_in_if;
	logic              valid;
	logic              ready;
	logic              req_type;
	cpg_pkg::center_t  center_x;
	cpg_pkg::center_t  center_y;
	cpg_pkg::radius_t  radius;
	modport source (output valid, req_type, center_x, center_y, radius, input ready);
	modport sink   (input valid, req_type, center_x, center_y, radius, output ready);
endinterface

### hw/rtl/cpg_out_if.sv
// Pixel channel of the circle point generator.
// Depends on cpg_pkg.
`timescale 1ns / 1ps
interface cpg_out_if;
	logic          valid;
	logic          ready;
	cpg_pkg::scr_t pixel_x;
	cpg_pkg::scr_t pixel_y;
	logic          pixel_color;
	logic          last_of_step;
	logic          circle_done;
	modport source (output valid, pixel_x, pixel_y, pixel_color, last_of_step, circle_done,
		input ready);
	modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_of_step, circle_done,
		output ready);
endinterface

### hw/rtl/cpg_cfg_if.sv
// Register write channel of the circle point generator.
// Depends on cpg_pkg.
`timescale 1ns / 1ps
interface cpg_cfg_if;
	logic               valid;
	logic               ready;
	cpg_pkg::cfg_idx_t  index;
	cpg_pkg::ucoord_t   data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/circle_point_generator_unit.sv
// Circle point generator top level: front end, step queue and pixel back end.
// Depends on cpg_pkg, the channel interfaces, cpg_front, cpg_queue and cpg_back.
//
// Usage: write algorithm (index 0), origin_x (1) and origin_y (2) on cfg while idle;
// cfg is always ready. Each request on req is either a start (centre, radius) or an
// advance. A start, or an advance while a circle runs, yields eight pixels on pix,
// one per cycle while pix is ready, last_of_step on the eighth; circle_done marks
// the final step. An advance with no circle running is accepted and yields nothing.
// An accepted step is written into the step queue, and the back end then loads its
// pixels one by one from the queue head into the single pixel output register; the
// two-entry step queue holds the step being drawn and one more, so req takes one
// request ahead of the pixels still draining.
// When pix stalls, the pixel register holds, the queue fills and req.ready drops.
// Reset clears the step state and queue; algorithm resets to Bresenham, origin to
// (319, 239).
`timescale 1ns / 1ps
module circle_point_generator_unit (
	input  logic     clk,
	input  logic     arst_n,
	cpg_in_if.sink   req,
	cpg_cfg_if.sink  cfg,
	cpg_out_if.source pix
);
	import cpg_pkg::*;

	push_t       qpush;
	queue_stat_t qstat;
	logic        pop;

	cpg_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cfg   (cfg),
		.qstat (qstat),
		.qpush (qpush)
	);

	cpg_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.qpush (qpush),
		.pop   (pop),
		.qstat (qstat)
	);

	cpg_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.qstat (qstat),
		.pop   (pop),
		.pix   (pix)
	);
endmodule

### hw/rtl/cpg_front.sv
// Front end: config registers, request decode and one decision step per start or per advance of a running circle.
// Depends on cpg_pkg, cpg_in_if and cpg_cfg_if.
`timescale 1ns / 1ps
module cpg_front (
	input  logic                  clk,
	input  logic                  arst_n,
	cpg_in_if.sink                req,
	cpg_cfg_if.sink               cfg,
	input  cpg_pkg::queue_stat_t  qstat,
	output cpg_pkg::push_t        qpush
);
	import cpg_pkg::*;

	logic    algo_q;
	ucoord_t origin_x_q;
	ucoord_t origin_y_q;
	coord_t  step_x_q;
	coord_t  step_y_q;
	dec_t    decision_q;
	scr_t    screen_cx_q;
	scr_t    screen_cy_q;
	logic    active_q;

	logic    accept;
	logic    is_start;
	coord_t  nx, ny;
	dec_t    nd, r_dec;
	scr_t    ncx, ncy;
	logic    ndone;

	assign cfg.ready = 1'b1;
	assign req.ready = !qstat.full;
	assign accept    = req.valid && req.ready;
	assign is_start  = (req.req_type == REQ_START);

	always_comb begin
		r_dec = dec_t'($signed({1'b0, req.radius}));
		nx  = step_x_q;
		ny  = step_y_q;
		nd  = decision_q;
		ncx = screen_cx_q;
		ncy = screen_cy_q;
		if (is_start) begin
			ncx = scr_t'({2'b00, origin_x_q}) + scr_t'(req.center_x);
			ncy = scr_t'({2'b00, origin_y_q}) - scr_t'(req.center_y);
			if (algo_q == ALGO_MID) begin
				nx = coord_t'($signed({1'b0, req.radius}));
				ny = '0;
				nd = dec_t'(1) - r_dec;
			end else begin
				nx = '0;
				ny = coord_t'($signed({1'b0, req.radius}));
				nd = dec_t'(3) - (r_dec <<< 1);
			end
		end else if (algo_q == ALGO_MID) begin
			ny = step_y_q + coord_t'(1);
			if (decision_q <= dec_t'(0)) begin
				nd = decision_q + (dec_t'(ny) <<< 1) + dec_t'(1);
			end else begin
				nx = step_x_q - coord_t'(1);
				nd = decision_q + (dec_t'(ny) <<< 1) - (dec_t'(nx) <<< 1) + dec_t'(1);
			end
		end else begin
			nx = step_x_q + coord_t'(1);
			if (decision_q > dec_t'(0)) begin
				ny = step_y_q - coord_t'(1);
				nd = decision_q + (dec_t'(nx) <<< 2) - (dec_t'(ny) <<< 2) + dec_t'(10);
			end else begin
				nd = decision_q + (dec_t'(nx) <<< 2) + dec_t'(6);
			end
		end
		ndone = (algo_q == ALGO_MID) ? (nx < ny) : (ny < nx);
	end

	assign qpush.push      = accept && (is_start || active_q);
	assign qpush.data.cx   = ncx;
	assign qpush.data.cy   = ncy;
	assign qpush.data.x    = nx;
	assign qpush.data.y    = ny;
	assign qpush.data.done = ndone;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			algo_q     <= ALGO_BRES;
			origin_x_q <= ORIGIN_X_RST;
			origin_y_q <= ORIGIN_Y_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ALGORITHM: algo_q     <= cfg.data[0];
				CFG_ORIGIN_X:  origin_x_q <= cfg.data;
				CFG_ORIGIN_Y:  origin_y_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q    <= '0;
			step_y_q    <= '0;
			decision_q  <= '0;
			screen_cx_q <= '0;
			screen_cy_q <= '0;
			active_q    <= 1'b0;
		end else if (qpush.push) begin
			step_x_q    <= nx;
			step_y_q    <= ny;
			decision_q  <= nd;
			screen_cx_q <= ncx;
			screen_cy_q <= ncy;
			active_q    <= !ndone;
		end
	end
endmodule

### hw/rtl/cpg_queue.sv
// Two-entry queue of decided steps between front end and pixel back end.
// Depends on cpg_pkg.
`timescale 1ns / 1ps
module cpg_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cpg_pkg::push_t        qpush,
	input  logic                  pop,
	output cpg_pkg::queue_stat_t  qstat
);
	import cpg_pkg::*;

	step_t      mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign qstat.full       = (count_q == 2'd2);
	assign qstat.head_valid = (count_q != 2'd0);
	assign qstat.head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (qpush.push) begin
			mem[wr_ptr_q] <= qpush.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (qpush.push) wr_ptr_q <= !wr_ptr_q;
			if (pop)        rd_ptr_q <= !rd_ptr_q;
			case ({qpush.push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`include "circle_point_generator_unit_assert.svh"
	`CPG_ASSERT_SAME(a_no_push_full, qpush.push, !qstat.full, "push into full queue")
	`CPG_ASSERT_SAME(a_no_pop_empty, pop, qstat.head_valid, "pop from empty queue")
	`CPG_ASSERT_SAME(a_count_range, 1'b1, count_q != 2'd3, "queue count out of range")
endmodule

### hw/rtl/cpg_back.sv
// Back end: walks the eight octant pixels of the head step into an output register.
// Depends on cpg_pkg and cpg_out_if.
`timescale 1ns / 1ps
module cpg_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cpg_pkg::queue_stat_t  qstat,
	output logic                  pop,
	cpg_out_if.source             pix
);
	import cpg_pkg::*;

	logic [2:0] oct_q;
	logic       out_valid_q;
	scr_t       px_q, py_q;
	logic       color_q, last_q, done_q;

	logic       load;
	scr_t       sx, sy, offx, offy;

	assign load = qstat.head_valid && (!out_valid_q || pix.ready);
	assign pop  = load && (oct_q == 3'd7);

	assign sx = scr_t'(qstat.head.x);
	assign sy = scr_t'(qstat.head.y);

	always_comb begin
		case (oct_q)
			3'd0:    begin offx =  sy; offy =  sx; end
			3'd1:    begin offx =  sx; offy =  sy; end
			3'd2:    begin offx =  sx; offy = -sy; end
			3'd3:    begin offx =  sy; offy = -sx; end
			3'd4:    begin offx = -sy; offy = -sx; end
			3'd5:    begin offx = -sx; offy = -sy; end
			3'd6:    begin offx = -sx; offy =  sy; end
			3'd7:    begin offx = -sy; offy =  sx; end
			default: begin offx = sy;  offy = sx;  end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				oct_q       <= oct_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (pix.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			px_q    <= qstat.head.cx + offx;
			py_q    <= qstat.head.cy + offy;
			color_q <= oct_q[0];
			last_q  <= (oct_q == 3'd7);
			done_q  <= qstat.head.done;
		end
	end

	assign pix.valid        = out_valid_q;
	assign pix.pixel_x      = px_q;
	assign pix.pixel_y      = py_q;
	assign pix.pixel_color  = color_q;
	assign pix.last_of_step = last_q;
	assign pix.circle_done  = done_q;

	`include "circle_point_generator_unit_assert.svh"
	`CPG_ASSERT_SAME(a_idle_octant, !qstat.head_valid, oct_q == 3'd0, "octant not at zero")
	`CPG_ASSERT_SAME(a_last_red, out_valid_q && last_q, color_q, "last pixel not red")
	`CPG_ASSERT_NEXT(a_load_shows, load, out_valid_q, "loaded pixel not shown")
endmodule

### bench/circle_point_generator_unit_tb.sv
// Self-checking bench for circle_point_generator_unit: drives start/advance requests
// and register writes, predicts the eight symmetric pixels of every step.
// Depends on cpg_pkg, cpg_in_if, cpg_cfg_if, cpg_out_if and the RTL top level.
`timescale 1ns / 1ps
module circle_point_generator_unit_tb;
	import cpg_pkg::*;

	typedef struct {
		logic    kind;
		center_t cx;
		center_t cy;
		radius_t rad;
	} circle_req_t;

	typedef struct {
		scr_t px;
		scr_t py;
		logic color;
		logic last;
		logic done;
	} pixel_t;

	logic clk;
	logic arst_n = 1'b0;

	// bench-side drivers, known from time zero
	logic     req_valid  = 1'b0;
	logic     req_kind   = REQ_START;
	center_t  req_cx     = '0;
	center_t  req_cy     = '0;
	radius_t  req_rad    = '0;
	logic     cfg_valid  = 1'b0;
	cfg_idx_t cfg_index  = CFG_ALGORITHM;
	ucoord_t  cfg_data   = '0;
	logic     pix_ready  = 1'b0;

	cpg_in_if  req_ch();
	cpg_cfg_if cfg_ch();
	cpg_out_if pix_ch();

	assign req_ch.valid    = req_valid;
	assign req_ch.req_type = req_kind;
	assign req_ch.center_x = req_cx;
	assign req_ch.center_y = req_cy;
	assign req_ch.radius   = req_rad;
	assign cfg_ch.valid    = cfg_valid;
	assign cfg_ch.index    = cfg_index;
	assign cfg_ch.data     = cfg_data;
	assign pix_ch.ready    = pix_ready;

	circle_point_generator_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.cfg    (cfg_ch),
		.pix    (pix_ch)
	);

	circle_req_t req_fifo[$];
	pixel_t      pixel_q[$];
	int          mismatches = 0;

	// shadow of the block's registers and step state
	logic    algo_sh  = ALGO_BRES;
	ucoord_t org_x_sh = ORIGIN_X_RST;
	ucoord_t org_y_sh = ORIGIN_Y_RST;
	coord_t  sx = '0;
	coord_t  sy = '0;
	dec_t    dv = '0;
	scr_t    ccx = '0;
	scr_t    ccy = '0;
	logic    drawing = 1'b0;

	int tx_gap = 0;
	int tx_calm = 0;
	int rx_stall = 0;
	int rx_calm = 0;
	int squeeze_cnt = 0;
	int squeeze_seen = 0;
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// mostly short gaps, a few long ones, and calm stretches with none
	function automatic int idle_len(inout int calm);
		int roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void emit_octants();
		int   x, y, cx, cy;
		int   dx[8], dy[8];
		logic fin;
		pixel_t p;
		x = int'(sx);
		y = int'(sy);
		cx = int'(ccx);
		cy = int'(ccy);
		dx = '{y, x, x, y, -y, -x, -x, -y};
		dy = '{x, y, -y, -x, -x, -y, y, x};
		fin = (algo_sh == ALGO_MID) ? (sx < sy) : (sy < sx);
		for (int k = 0; k < 8; k++) begin
			p.px = scr_t'(cx + dx[k]);
			p.py = scr_t'(cy + dy[k]);
			p.color = k[0];
			p.last = (k == 7);
			p.done = fin;
			pixel_q.push_back(p);
		end
		if (fin)
			drawing = 1'b0;
	endfunction

	function automatic void step_circle(logic kind, center_t c_x, center_t c_y, radius_t rad);
		int r;
		r = int'(rad);
		if (kind == REQ_START) begin
			ccx = scr_t'(int'(org_x_sh) + int'(c_x));
			ccy = scr_t'(int'(org_y_sh) - int'(c_y));
			if (algo_sh == ALGO_MID) begin
				sx = coord_t'(r);
				sy = '0;
				dv = dec_t'(1 - r);
			end else begin
				sx = '0;
				sy = coord_t'(r);
				dv = dec_t'(3 - 2 * r);
			end
			drawing = 1'b1;
			emit_octants();
		end else if (drawing) begin
			if (algo_sh == ALGO_MID) begin
				sy = coord_t'(int'(sy) + 1);
				if (dv <= 0) begin
					dv = dec_t'(int'(dv) + 2 * int'(sy) + 1);
				end else begin
					sx = coord_t'(int'(sx) - 1);
					dv = dec_t'(int'(dv) + 2 * int'(sy) - 2 * int'(sx) + 1);
				end
			end else begin
				sx = coord_t'(int'(sx) + 1);
				if (dv > 0) begin
					sy = coord_t'(int'(sy) - 1);
					dv = dec_t'(int'(dv) + 4 * int'(sx) - 4 * int'(sy) + 10);
				end else begin
					dv = dec_t'(int'(dv) + 4 * int'(sx) + 6);
				end
			end
			emit_octants();
		end
	endfunction

	task automatic note_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_pixel();
		pixel_t want;
		if (pixel_q.size() == 0) begin
			note_mismatch($sformatf("pixel x=%0d y=%0d with nothing expected",
				pix_ch.pixel_x, pix_ch.pixel_y));
			return;
		end
		want = pixel_q.pop_front();
		if (pix_ch.pixel_x !== want.px || pix_ch.pixel_y !== want.py ||
				pix_ch.pixel_color !== want.color || pix_ch.last_of_step !== want.last ||
				pix_ch.circle_done !== want.done)
			note_mismatch($sformatf(
				"expected x=%0d y=%0d color=%0b last=%0b done=%0b, actual x=%0d y=%0d color=%0b last=%0b done=%0b",
				want.px, want.py, want.color, want.last, want.done,
				pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.pixel_color,
				pix_ch.last_of_step, pix_ch.circle_done));
	endtask

	function automatic void queue_req(logic kind, int cx, int cy, int r);
		circle_req_t it;
		it.kind = kind;
		it.cx = center_t'(cx);
		it.cy = center_t'(cy);
		it.rad = radius_t'(r);
		req_fifo.push_back(it);
	endfunction

	// one circle: a start and a run of advances, sometimes past the end, or a lone
	// advance; returns the requests queued for a circle, or zero for a lone advance
	function automatic int add_circle();
		int roll, rad, steps;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			queue_req(REQ_ADVANCE, $urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 2047));
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 70)
			rad = $urandom_range(0, 24);
		else if (roll < 90)
			rad = $urandom_range(25, 200);
		else
			rad = $urandom_range(0, 2047);
		if (rad <= 24)
			steps = $urandom_range(0, rad * 3 / 4 + 3);
		else
			steps = $urandom_range(0, 20);
		queue_req(REQ_START, $urandom_range(0, 4095), $urandom_range(0, 4095), rad);
		for (int i = 0; i < steps; i++)
			queue_req(REQ_ADVANCE, $urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 2047));
		return 1 + steps;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		circle_req_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
			tx_gap = 0;
		end else if (!req_valid || req_ch.ready) begin
			if (tx_gap > 0) begin
				tx_gap--;
				req_valid <= 1'b0;
			end else if (req_fifo.size() != 0) begin
				nxt = req_fifo.pop_front();
				req_valid <= 1'b1;
				req_kind <= nxt.kind;
				req_cx <= nxt.cx;
				req_cy <= nxt.cy;
				req_rad <= nxt.rad;
				tx_gap = idle_len(tx_calm);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, armed from the stimulus
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (squeeze_cnt != squeeze_seen) begin
			squeeze_seen <= squeeze_cnt;
			hold_left <= 300;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor: check pixels, track register writes, predict accepted requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (pix_ch.valid && pix_ch.ready)
				check_pixel();
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					CFG_ALGORITHM: algo_sh = cfg_ch.data[0];
					CFG_ORIGIN_X: org_x_sh = cfg_ch.data;
					CFG_ORIGIN_Y: org_y_sh = cfg_ch.data;
					default: ;
				endcase
			end
			if (req_ch.valid && req_ch.ready)
				step_circle(req_ch.req_type, req_ch.center_x, req_ch.center_y, req_ch.radius);
			if (rx_stall > 0) begin
				rx_stall--;
				pix_ready <= 1'b0;
			end else begin
				rx_stall = idle_len(rx_calm);
				if (rx_stall > 0) begin
					rx_stall--;
					pix_ready <= 1'b0;
				end else begin
					pix_ready <= (hold_left == 0);
				end
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, ucoord_t val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_valid <= 1'b0;
	endtask

	// all requests sent and every pixel seen; advances that yield nothing may still
	// be in flight, so allow a few cycles more
	task automatic wait_drained();
		do @(negedge clk); while (req_fifo.size() != 0 || req_valid || pixel_q.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		int planned;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings, Bresenham
		queue_req(REQ_ADVANCE, 0, 0, 0);           // nothing running
		queue_req(REQ_START, 0, 0, 0);             // zero radius
		queue_req(REQ_ADVANCE, 0, 0, 0);
		queue_req(REQ_ADVANCE, -1, -1, 2047);      // after the circle is done
		queue_req(REQ_START, -2048, 2047, 2047);
		queue_req(REQ_ADVANCE, 2047, -2048, 0);
		queue_req(REQ_ADVANCE, 0, 0, 0);
		queue_req(REQ_START, 2047, -2048, 5);      // drops the running circle
		for (int i = 0; i < 5; i++)
			queue_req(REQ_ADVANCE, 0, 0, 0);
		wait_drained();

		write_reg(CFG_ALGORITHM, ucoord_t'(ALGO_MID));
		write_reg(CFG_ORIGIN_X, ucoord_t'(4095));
		write_reg(CFG_ORIGIN_Y, ucoord_t'(0));
		@(negedge clk);
		queue_req(REQ_START, 0, 0, 0);
		queue_req(REQ_ADVANCE, 0, 0, 0);
		queue_req(REQ_START, 100, -100, 4);
		for (int i = 0; i < 4; i++)
			queue_req(REQ_ADVANCE, 0, 0, 0);
		queue_req(REQ_START, 5, 5, 40);
		queue_req(REQ_ADVANCE, 0, 0, 0);
		queue_req(REQ_ADVANCE, 0, 0, 0);
		wait_drained();

		// rule switch with a circle still running
		write_reg(CFG_ALGORITHM, ucoord_t'(ALGO_BRES));
		@(negedge clk);
		for (int i = 0; i < 3; i++)
			queue_req(REQ_ADVANCE, 0, 0, 0);

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			write_reg(CFG_ALGORITHM, ucoord_t'(ph % 2 == 0 ? ALGO_MID : ALGO_BRES));
			if (ph == 0) begin
				write_reg(CFG_ORIGIN_X, ucoord_t'(0));
				write_reg(CFG_ORIGIN_Y, ucoord_t'(4095));
			end else if (ph == 1) begin
				write_reg(CFG_ORIGIN_X, ucoord_t'(4095));
				write_reg(CFG_ORIGIN_Y, ucoord_t'(0));
			end else begin
				write_reg(CFG_ORIGIN_X, ucoord_t'($urandom_range(0, 4095)));
				write_reg(CFG_ORIGIN_Y, ucoord_t'($urandom_range(0, 4095)));
			end
			@(negedge clk);
			if (ph == 2)
				squeeze_cnt++;
			planned = 0;
			while (planned < 50)
				planned += add_circle();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end
endmodule

### circle_point_generator_unit.f
+incdir+hw/rtl
hw/rtl/cpg_pkg.sv
hw/rtl/cpg_in_if.sv
hw/rtl/cpg_out_if.sv
hw/rtl/cpg_cfg_if.sv
hw/rtl/cpg_front.sv
hw/rtl/cpg_queue.sv
hw/rtl/cpg_back.sv
hw/rtl/circle_point_generator_unit.sv
bench/circle_point_generator_unit_tb.sv
